// File: rtl/core/adc_pkg.sv
// Package for the argmax Dice score block: widths, the sample record and helpers.
// No dependencies; every other file depends on it.
`timescale 1ns / 1ps
package adc_pkg;
	localparam int NUM_CLASSES = 8;
	localparam int CLS_W       = 3;
	localparam int CC_W        = 4;
	localparam int PROB_W      = 16;
	localparam int CNT_W       = 25;
	localparam int TOTAL_W     = 26;
	localparam int PRES_W      = 9;
	localparam int MEAN_W      = 17;
	localparam int DEN_W       = 26;
	localparam int REM_W       = 26;
	localparam int DIV_STEPS   = 17;
	localparam int STEP_W      = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CC_W-1:0]   CC_RESET = 4'd8;
	localparam logic [CC_W-1:0]   CC_MIN   = 4'd2;
	localparam logic [CC_W-1:0]   CC_MAX   = CC_W'(NUM_CLASSES);
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [PRES_W-1:0] PRES_MAX = {PRES_W{1'b1}};

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		cnt_t [NUM_CLASSES-1:0] isect;
		cnt_t [NUM_CLASSES-1:0] pred;
		cnt_t [NUM_CLASSES-1:0] truth;
		logic [CC_W-1:0]        k;
		logic                   last;
	} sample_t;

	function automatic cnt_t sat_inc(input cnt_t v, input logic en);
		sat_inc = (en && v != CNT_MAX) ? v + cnt_t'(1) : v;
	endfunction
endpackage

// File: rtl/core/adc_ifs.sv
// Channel interfaces: voxel input and score output, valid/ready handshake.
// Depends on adc_pkg.
`timescale 1ns / 1ps
interface voxel_if;
	logic                       valid;
	logic                       ready;
	logic [adc_pkg::PROB_W-1:0] prob_class0;
	logic [adc_pkg::PROB_W-1:0] prob_class1;
	logic [adc_pkg::PROB_W-1:0] prob_class2;
	logic [adc_pkg::PROB_W-1:0] prob_class3;
	logic [adc_pkg::PROB_W-1:0] prob_class4;
	logic [adc_pkg::PROB_W-1:0] prob_class5;
	logic [adc_pkg::PROB_W-1:0] prob_class6;
	logic [adc_pkg::PROB_W-1:0] prob_class7;
	logic [adc_pkg::CLS_W-1:0]  true_label;
	logic                       last_voxel;
	logic                       last_sample;
	modport source (output valid, prob_class0, prob_class1, prob_class2, prob_class3,
		prob_class4, prob_class5, prob_class6, prob_class7, true_label, last_voxel,
		last_sample, input ready);
	modport sink (input valid, prob_class0, prob_class1, prob_class2, prob_class3,
		prob_class4, prob_class5, prob_class6, prob_class7, true_label, last_voxel,
		last_sample, output ready);
endinterface

interface score_if;
	logic                       valid;
	logic                       ready;
	logic [adc_pkg::MEAN_W-1:0] mean_dice;
	logic [adc_pkg::PRES_W-1:0] present_classes;
	modport source (output valid, mean_dice, present_classes, input ready);
	modport sink (input valid, mean_dice, present_classes, output ready);
endinterface

// File: rtl/core/adc_front.sv
// Front end: class count register, argmax per voxel and per-class sample counters.
// Depends on adc_pkg and voxel_if; pushes closed samples into adc_queue.
`timescale 1ns / 1ps
module adc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	voxel_if.sink                    vox,
	input  logic                     cfg_we,
	input  logic [adc_pkg::CC_W-1:0] cfg_wdata,
	output logic                     push,
	output adc_pkg::sample_t         entry,
	input  logic                     full
);
	import adc_pkg::*;

	logic [CC_W-1:0]   class_count_q;
	logic [CC_W-1:0]   k;
	logic [PROB_W-1:0] prob [NUM_CLASSES];
	logic [CLS_W-1:0]  best;
	logic [PROB_W-1:0] best_val;
	logic              label_ok;
	logic              accept;
	logic              close;
	cnt_t              isect_q [NUM_CLASSES];
	cnt_t              pred_q  [NUM_CLASSES];
	cnt_t              truth_q [NUM_CLASSES];
	cnt_t              isect_d [NUM_CLASSES];
	cnt_t              pred_d  [NUM_CLASSES];
	cnt_t              truth_d [NUM_CLASSES];

	always_comb begin
		if (class_count_q < CC_MIN) begin
			k = CC_MIN;
		end else if (class_count_q > CC_MAX) begin
			k = CC_MAX;
		end else begin
			k = class_count_q;
		end
	end

	assign prob[0] = vox.prob_class0;
	assign prob[1] = vox.prob_class1;
	assign prob[2] = vox.prob_class2;
	assign prob[3] = vox.prob_class3;
	assign prob[4] = vox.prob_class4;
	assign prob[5] = vox.prob_class5;
	assign prob[6] = vox.prob_class6;
	assign prob[7] = vox.prob_class7;

	// first maximum wins
	always_comb begin
		best     = '0;
		best_val = prob[0];
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (CC_W'(c) < k && prob[c] > best_val) begin
				best     = CLS_W'(c);
				best_val = prob[c];
			end
		end
	end

	assign label_ok  = {1'b0, vox.true_label} < k;
	assign accept    = vox.valid && !full;
	assign close     = vox.last_voxel || vox.last_sample;
	assign vox.ready = !full;
	assign push      = accept && close;

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			pred_d[c]  = sat_inc(pred_q[c], best == CLS_W'(c));
			truth_d[c] = sat_inc(truth_q[c], label_ok && vox.true_label == CLS_W'(c));
			isect_d[c] = sat_inc(isect_q[c],
				label_ok && vox.true_label == CLS_W'(c) && best == CLS_W'(c));
			entry.isect[c] = isect_d[c];
			entry.pred[c]  = pred_d[c];
			entry.truth[c] = truth_d[c];
		end
		entry.k    = k;
		entry.last = vox.last_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CC_RESET;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				isect_q[c] <= '0;
				pred_q[c]  <= '0;
				truth_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				class_count_q <= cfg_wdata;
			end
			if (accept) begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					isect_q[c] <= close ? '0 : isect_d[c];
					pred_q[c]  <= close ? '0 : pred_d[c];
					truth_q[c] <= close ? '0 : truth_d[c];
				end
			end
		end
	end
endmodule

// File: rtl/core/adc_queue.sv
// Short queue of closed sample records between front and back end.
// Depends on adc_pkg.
`timescale 1ns / 1ps
module adc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  adc_pkg::sample_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output adc_pkg::sample_t head
);
	import adc_pkg::*;

	sample_t    mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'(QUEUE_DEPTH);
	assign valid = cnt_q != 2'd0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: rtl/core/adc_back.sv
// Back end: per-class Dice by a shared bit-serial divider, batch totals and mean.
// Depends on adc_pkg and score_if; pops sample records from adc_queue.
`timescale 1ns / 1ps
module adc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  adc_pkg::sample_t q_head,
	output logic             pop,
	score_if.source          score
);
	import adc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_MEAN  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]          state_q;
	logic [CC_W-1:0]     cls_q;
	logic [REM_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [MEAN_W-1:0]   quo_q;
	logic [MEAN_W-1:0]   lo_q;
	logic [STEP_W-1:0]   step_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [PRES_W-1:0]   present_q;
	logic                out_valid_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [PRES_W-1:0]   pres_out_q;
	logic [REM_W:0]      r2;
	logic                ge;
	logic [MEAN_W-1:0]   quo_d;
	logic [CLS_W-1:0]    ci;
	logic                last_step;
	logic                load_out;

	assign ci        = cls_q[CLS_W-1:0];
	assign r2        = {rem_q, lo_q[MEAN_W-1]};
	assign ge        = r2 >= {1'b0, den_q};
	assign quo_d     = {quo_q[MEAN_W-2:0], ge};
	assign last_step = step_q == STEP_W'(DIV_STEPS - 1);
	assign load_out  = state_q == S_OUT && (!out_valid_q || score.ready);
	assign pop       = load_out || (state_q == S_CHECK && cls_q >= q_head.k && !q_head.last);

	assign score.valid           = out_valid_q;
	assign score.mean_dice       = mean_q;
	assign score.present_classes = pres_out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK: begin
				quo_q  <= '0;
				step_q <= '0;
				if (cls_q >= q_head.k) begin
					rem_q <= REM_W'(total_q[TOTAL_W-1:MEAN_W]);
					lo_q  <= total_q[MEAN_W-1:0];
					den_q <= DEN_W'(present_q);
				end else begin
					rem_q <= REM_W'(q_head.isect[ci]);
					lo_q  <= '0;
					den_q <= DEN_W'(q_head.pred[ci]) + DEN_W'(q_head.truth[ci]);
				end
			end
			S_DIV, S_MEAN: begin
				rem_q  <= ge ? REM_W'(r2 - {1'b0, den_q}) : REM_W'(r2);
				lo_q   <= {lo_q[MEAN_W-2:0], 1'b0};
				quo_q  <= quo_d;
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			mean_q     <= (present_q == '0) ? '0 : quo_q;
			pres_out_q <= present_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cls_q       <= '0;
			total_q     <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (score.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cls_q <= CC_W'(1);
					if (q_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cls_q >= q_head.k) begin
						state_q <= q_head.last ? S_MEAN : S_IDLE;
					end else if (q_head.truth[ci] != '0 && present_q != PRES_MAX) begin
						state_q <= S_DIV;
					end else begin
						cls_q <= cls_q + CC_W'(1);
					end
				end
				S_DIV: begin
					if (last_step) begin
						total_q   <= total_q + TOTAL_W'(quo_d);
						present_q <= present_q + PRES_W'(1);
						cls_q     <= cls_q + CC_W'(1);
						state_q   <= S_CHECK;
					end
				end
				S_MEAN: begin
					if (last_step) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						total_q   <= '0;
						present_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop with empty queue");
	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0)
		else $error("dice divisor is zero");
	a_mean_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && present_q != '0 |-> quo_q <= MEAN_W'(65536))
		else $error("mean exceeds one");
	a_out_after_mean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> $past(state_q) == S_MEAN || $past(state_q) == S_OUT)
		else $error("result without mean division");
endmodule

// File: rtl/core/argmax_dice_score_top.sv
// Top level of the argmax Dice score block: front end, sample queue, back end.
// Depends on adc_pkg, voxel_if, score_if, adc_front, adc_queue and adc_back.
//
//  channel | dir | handshake          | payload
//  vox     | in  | valid/ready        | prob_class0..7, true_label, last_voxel, last_sample
//  score   | out | valid/ready        | mean_dice, present_classes
//  cfg     | in  | cfg_we, no wait    | cfg_wdata = class_count
//
// Voxels transfer one per cycle while the two-entry sample queue has room.
// Each closed sample takes the back end through a check per class and a division per
// present class (one bit-serial divider); a batch end adds the mean division and a load.
// The front stalls only when the queue is full; a pending result holds the back end.
// Reset clears all counters and totals; class_count resets to 8.
`timescale 1ns / 1ps
module argmax_dice_score_top (
	input  logic                     clk,
	input  logic                     arst_n,
	voxel_if.sink                    vox,
	score_if.source                  score,
	input  logic                     cfg_we,
	input  logic [adc_pkg::CC_W-1:0] cfg_wdata
);
	import adc_pkg::*;

	logic    push;
	logic    full;
	logic    pop;
	logic    q_valid;
	sample_t wr_entry;
	sample_t q_head;

	adc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vox       (vox),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.entry     (wr_entry),
		.full      (full)
	);

	adc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	adc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.score   (score)
	);
endmodule

// File: tb/sv/adc_scoreboard.sv
// Scoreboard for the argmax Dice score block: per-class counters, batch totals, result queue.
// Depends on adc_pkg.
`timescale 1ns / 1ps
class dice_scoreboard;
	typedef struct packed {
		logic [adc_pkg::MEAN_W-1:0] mean;
		logic [adc_pkg::PRES_W-1:0] pres;
	} score_t;

	logic [24:0] isect_cnt[8];
	logic [24:0] pred_cnt[8];
	logic [24:0] truth_cnt[8];
	logic [25:0] dice_sum;
	logic [8:0]  pres_sum;
	logic [3:0]  classes;
	score_t      pending[$];
	int          errors;
	int          matched;

	function new();
		classes = adc_pkg::CC_RESET;
		dice_sum = 0;
		pres_sum = 0;
		errors = 0;
		matched = 0;
		clear_counts();
	endfunction

	function void clear_counts();
		for (int c = 0; c < 8; c++) begin
			isect_cnt[c] = 0;
			pred_cnt[c] = 0;
			truth_cnt[c] = 0;
		end
	endfunction

	function logic [24:0] bump(logic [24:0] v);
		return (v == adc_pkg::CNT_MAX) ? v : v + 25'd1;
	endfunction

	function void note_voxel(logic [15:0] p[8], logic [2:0] lbl, logic lv, logic ls);
		int k;
		int best;
		longint num;
		longint den;
		score_t r;
		k = (classes < 2) ? 2 : ((classes > 8) ? 8 : classes);
		best = 0;
		for (int c = 1; c < k; c++)
			if (p[c] > p[best])
				best = c;
		pred_cnt[best] = bump(pred_cnt[best]);
		if (lbl < k) begin
			truth_cnt[lbl] = bump(truth_cnt[lbl]);
			if (lbl == best)
				isect_cnt[lbl] = bump(isect_cnt[lbl]);
		end
		if (lv || ls) begin
			for (int c = 1; c < k; c++)
				if (truth_cnt[c] != 0 && pres_sum != 9'd511) begin
					num = 2 * longint'(isect_cnt[c]) * 65536;
					den = longint'(pred_cnt[c]) + longint'(truth_cnt[c]);
					dice_sum = dice_sum + 26'(num / den);
					pres_sum = pres_sum + 9'd1;
				end
			clear_counts();
		end
		if (ls) begin
			r.mean = (pres_sum != 0) ? 17'(dice_sum / pres_sum) : 17'd0;
			r.pres = pres_sum;
			pending.push_back(r);
			dice_sum = 0;
			pres_sum = 0;
		end
	endfunction

	function void check_score(logic [16:0] mean, logic [8:0] pres);
		score_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected score: mean %0d present %0d", mean, pres);
			return;
		end
		e = pending.pop_front();
		if (e.mean !== mean || e.pres !== pres) begin
			errors++;
			if (errors <= 10)
				$display("score mismatch: exp mean %0d present %0d, got mean %0d present %0d",
					e.mean, e.pres, mean, pres);
		end else
			matched++;
	endfunction
endclass

// File: tb/sv/testbench.sv
// Testbench for argmax_dice_score_top: random voxel batches checked against a scoreboard.
// Depends on adc_pkg, adc_ifs, adc_scoreboard and the RTL.
`timescale 1ns / 1ps
module testbench;
	import adc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	int          src_idle;
	int          snk_stall;
	int          sent;
	longint      cycles;
	int          wr;
	dice_scoreboard sb;

	voxel_if vox();
	score_if score();

	argmax_dice_score_top DUT (
		.clk(clk), .arst_n(arst_n), .vox(vox), .score(score),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("timeout");
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && score.valid && score.ready)
			sb.check_score(score.mean_dice, score.present_classes);
		score.ready <= ($urandom_range(99) >= snk_stall);
	end

	task automatic send_voxel(logic [15:0] p[8], logic [2:0] lbl, logic lv, logic ls);
		while (src_idle > 0 && $urandom_range(99) < src_idle) begin
			vox.valid <= 0;
			@(posedge clk);
		end
		vox.valid <= 1;
		vox.prob_class0 <= p[0]; vox.prob_class1 <= p[1];
		vox.prob_class2 <= p[2]; vox.prob_class3 <= p[3];
		vox.prob_class4 <= p[4]; vox.prob_class5 <= p[5];
		vox.prob_class6 <= p[6]; vox.prob_class7 <= p[7];
		vox.true_label <= lbl;
		vox.last_voxel <= lv;
		vox.last_sample <= ls;
		@(posedge clk);
		while (!vox.ready)
			@(posedge clk);
		sb.note_voxel(p, lbl, lv, ls);
		sent++;
	endtask

	task automatic random_voxel(bit lv, bit ls);
		logic [15:0] p[8];
		int m;
		m = $urandom_range(3);
		for (int c = 0; c < 8; c++)
			case (m)
				0: p[c] = 16'($urandom);
				1: p[c] = 16'($urandom_range(3) * 16'h5555);
				2: p[c] = $urandom_range(1) ? 16'hffff : 16'h0000;
				default: p[c] = 16'($urandom_range(4));
			endcase
		send_voxel(p, 3'($urandom_range(7)), lv, ls);
	endtask

	task automatic settle();
		vox.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_classes(logic [3:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.classes = v;
		wr++;
	endtask

	task automatic random_batches(int n);
		int nv;
		int ns;
		while (n > 0) begin
			ns = $urandom_range(4);
			for (int s = 0; s < ns && n > 0; s++) begin
				nv = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
				for (int v = 0; v < nv; v++) begin
					random_voxel(v == nv - 1 || $urandom_range(19) == 0, 0);
					n--;
				end
			end
			random_voxel(1'($urandom_range(1)), 1);
			n--;
		end
	endtask

	initial begin
		logic [15:0] p[8];
		logic [3:0] settings[6];
		settings = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd3};
		sb = new();
		cycles = 0; sent = 0; wr = 0;
		src_idle = 0; snk_stall = 0;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0;
		vox.valid = 0; score.ready = 0;
		vox.prob_class0 = 0; vox.prob_class1 = 0; vox.prob_class2 = 0; vox.prob_class3 = 0;
		vox.prob_class4 = 0; vox.prob_class5 = 0; vox.prob_class6 = 0; vox.prob_class7 = 0;
		vox.true_label = 0; vox.last_voxel = 0; vox.last_sample = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: ties, extremes, unused labels, last_sample alone, empty batch
		for (int c = 0; c < 8; c++) p[c] = 16'hffff;
		send_voxel(p, 3'd0, 1'b0, 1'b0);
		send_voxel(p, 3'd7, 1'b1, 1'b0);
		for (int c = 0; c < 8; c++) p[c] = 0;
		send_voxel(p, 3'd0, 1'b0, 1'b1);
		send_voxel(p, 3'd3, 1'b0, 1'b1);
		for (int c = 0; c < 8; c++) begin
			p[c] = 16'hffff;
			send_voxel(p, 3'(c), 1'b0, 1'b0);
			send_voxel(p, 3'(7 - c), 1'b1, 1'b0);
			p[c] = 0;
		end
		p[7] = 16'h8000; p[2] = 16'h8000;
		send_voxel(p, 3'd7, 1'b1, 1'b1);
		settle();
		write_classes(4'd3);
		p[7] = 16'hffff;
		send_voxel(p, 3'd7, 1'b0, 1'b0);
		send_voxel(p, 3'd5, 1'b1, 1'b1);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 69; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 69; end
				default: begin src_idle = 38; snk_stall = 38; end
			endcase
			for (int s = 0; s < 6; s++) begin
				write_classes(settings[(s + ph) % 6]);
				random_batches(65);
				settle();
			end
			src_idle = 0; snk_stall = 0;
			random_batches(10);
			settle();
		end
		// many one-voxel samples in one batch with eight classes
		write_classes(4'd8);
		for (int v = 0; v < 90; v++)
			random_voxel(1, v == 89);
		settle();

		$display("Sent %0d voxels, %0d register writes, %0d scores matched.",
			sent, wr, sb.matched);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
